// ----- rtl/rsd_pkg.sv -----
// Shared widths, reset values and base clamping for the radix digit converter.
package rsd_pkg;

    localparam int ADDEND_W       = 30;
    localparam int SUM_W          = ADDEND_W + 1;
    localparam int BASE_W         = 5;
    localparam int DIGIT_W        = 4;
    localparam int MAX_DIGITS_DEF = 32;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

    // clamp the programmed radix into 2..16
    function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

// ----- rtl/rsd_divider.sv -----
// Restoring divider, one quotient bit per cycle: sum by small radix.
module rsd_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rsd_pkg::SUM_W-1:0]  i_dividend,
    input  logic [rsd_pkg::BASE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rsd_pkg::SUM_W-1:0]  o_quotient,
    output logic [rsd_pkg::DIGIT_W-1:0] o_remainder
);
    import rsd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic                r_run;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    r_q;
    logic [DIGIT_W-1:0]  r_rem;
    logic [BASE_W-1:0]   r_div;

    logic [BASE_W-1:0]   w_trial;
    logic [BASE_W-1:0]   w_diff;
    logic                w_ge;
    logic [DIGIT_W-1:0]  n_rem;

    // trial subtract; remainder stays below the divisor, so 4 bits hold it
    always_comb begin
        w_trial = {r_rem, r_q[SUM_W-1]};
        w_ge    = (w_trial >= r_div);
        w_diff  = w_trial - r_div;
        n_rem   = w_ge ? w_diff[DIGIT_W-1:0] : w_trial[DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_q   <= {r_q[SUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

// ----- rtl/radix_sum_digits.sv -----
// Top level: adds two addends and streams the sum's digits in a set radix.
//
// Use:
//   Configuration: i_cfg_we writes i_cfg_number_base (radix) at the clock
//   edge; values below 2 act as 2, above 16 as 16. Write only while idle.
//   Input: an item (i_addend_a, i_addend_b) is taken at an edge where start
//   is high and busy is low. busy stays high until the last digit is read
//   out of the digit store.
//   Output: each digit appears on o_digit_value for one cycle with o_strobe
//   high, most significant first; o_last_digit marks the least significant
//   digit. A zero sum gives the single digit 0. The receiver cannot stall,
//   so digits leave at one per cycle without back-pressure.
//   Timing: each digit costs one division of the running quotient by the
//   radix in the shared bit-serial divider: a launch, one shift step per
//   sum bit and a hand-back. An item has at most 31 digits (radix 2). The
//   divisions set an item's duration; read-out runs one digit per cycle
//   from the store.
//   Reset: synchronous, active low; returns to idle and radix 10. Digit
//   store contents are left as they are and are always rewritten first.
module radix_sum_digits #(
    parameter int MAX_DIGITS = rsd_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rsd_pkg::BASE_W-1:0]   i_cfg_number_base,
    input  logic                         start,
    input  logic [rsd_pkg::ADDEND_W-1:0] i_addend_a,
    input  logic [rsd_pkg::ADDEND_W-1:0] i_addend_b,
    output logic                         busy,
    output logic                         o_strobe,
    output logic [rsd_pkg::DIGIT_W-1:0]  o_digit_value,
    output logic                         o_last_digit
);
    import rsd_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LAUNCH = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

    t_state              r_state;
    logic [BASE_W-1:0]   r_number_base;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [SUM_W-1:0]    r_quot;
    logic [IDX_W-1:0]    r_rd_addr;
    logic                r_strobe;
    logic                r_last;
    logic [DIGIT_W-1:0]  r_rd_data;
    logic [DIGIT_W-1:0]  r_mem [MAX_DIGITS];

    logic                w_div_start;
    logic                w_div_done;
    logic [SUM_W-1:0]    w_div_quot;
    logic [DIGIT_W-1:0]  w_div_rem;
    logic                w_accept;
    logic                w_more;

    assign w_accept    = start && (r_state == ST_IDLE);
    assign w_div_start = (r_state == ST_LAUNCH);
    assign n_cnt       = r_cnt + CNT_W'(1);
    // another division only while the quotient is nonzero and room is left
    assign w_more      = (w_div_quot != '0) && (n_cnt != CNT_W'(MAX_DIGITS));

    rsd_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_quot),
        .i_divisor   (eff_base(r_number_base)),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quot),
        .o_remainder (w_div_rem)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_number_base <= BASE_RESET;
            r_cnt         <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_number_base <= i_cfg_number_base;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cnt   <= '0;
                        r_state <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_div_done) begin
                        r_cnt   <= n_cnt;
                        r_state <= w_more ? ST_LAUNCH : ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    r_strobe <= 1'b1;
                    if (r_rd_addr == '0) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath: running quotient, read pointer, last flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot <= '0;
        end else if (w_accept) begin
            r_quot <= SUM_W'(i_addend_a) + SUM_W'(i_addend_b);
        end else if ((r_state == ST_WAIT) && w_div_done) begin
            r_quot    <= w_div_quot;
            r_rd_addr <= r_cnt[IDX_W-1:0];
        end else if (r_state == ST_EMIT) begin
            r_rd_addr <= r_rd_addr - IDX_W'(1);
        end
        r_last <= (r_rd_addr == '0);
    end

    // digit store: written least significant first, read back in reverse
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WAIT) && w_div_done) begin
            r_mem[r_cnt[IDX_W-1:0]] <= w_div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_rd_addr];
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_digit_value = r_rd_data;
    assign o_last_digit  = r_last;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for radix_sum_digits: directed and random items, digit predictor.
`timescale 1ns / 1ps

module testbench;
    import rsd_pkg::*;

    localparam logic [ADDEND_W-1:0] ADDEND_MAX = {ADDEND_W{1'b1}};
    // Cycles with neither an item taken nor a digit out, before the watchdog fails.
    localparam int unsigned STALL_LIMIT = 8000;
    localparam int unsigned MAX_SHOWN   = 10;

    typedef struct packed {
        logic [DIGIT_W-1:0] value;
        logic               last;
    } t_digit;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [BASE_W-1:0]   i_cfg_number_base = '0;
    logic                start = 1'b0;
    logic [ADDEND_W-1:0] i_addend_a = '0;
    logic [ADDEND_W-1:0] i_addend_b = '0;
    logic                busy;
    logic                o_strobe;
    logic [DIGIT_W-1:0]  o_digit_value;
    logic                o_last_digit;

    // predictor state: programmed radix and digits still owed by the block
    logic [BASE_W-1:0]   radix_reg = BASE_RESET;
    t_digit              digits_due[$];
    int unsigned         mismatches = 0;
    int unsigned         idle_cycles = 0;
    bit                  no_gaps = 1'b0;

    radix_sum_digits u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_number_base (i_cfg_number_base),
        .start             (start),
        .i_addend_a        (i_addend_a),
        .i_addend_b        (i_addend_b),
        .busy              (busy),
        .o_strobe          (o_strobe),
        .o_digit_value     (o_digit_value),
        .o_last_digit      (o_last_digit)
    );

    always #5 i_clk = ~i_clk;

    // Sum the addends and split the sum into digits of the clamped radix,
    // queued most significant first with the final digit marked.
    function automatic void predict_digits(input logic [ADDEND_W-1:0] a,
                                           input logic [ADDEND_W-1:0] b);
        logic [SUM_W-1:0]   quot;
        logic [DIGIT_W-1:0] lsd_first[$];
        int unsigned        radix;
        t_digit             d;
        radix = (radix_reg < BASE_MIN) ? BASE_MIN :
                (radix_reg > BASE_MAX) ? BASE_MAX : radix_reg;
        quot  = SUM_W'(a) + SUM_W'(b);
        // zero sum still gives one digit
        do begin
            lsd_first.push_back(DIGIT_W'(quot % radix));
            quot = quot / radix;
        end while (quot != 0);
        for (int k = lsd_first.size() - 1; k >= 0; k--) begin
            d.value = lsd_first[k];
            d.last  = (k == 0);
            digits_due.push_back(d);
        end
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Digits are accepted at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        t_digit want;
        if (i_rst_n && o_strobe) begin
            if (digits_due.size() == 0) begin
                note_mismatch("digit with none outstanding", o_digit_value, 0);
            end else begin
                want = digits_due.pop_front();
                if (o_digit_value !== want.value) begin
                    note_mismatch("digit_value", o_digit_value, want.value);
                end
                if (o_last_digit !== want.last) begin
                    note_mismatch("last_digit", o_last_digit, want.last);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("radix_sum_digits verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One item: optional gap, then start held until the block is free.
    task automatic send_item(input logic [ADDEND_W-1:0] a, input logic [ADDEND_W-1:0] b);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_addend_a <= a;
        i_addend_b <= b;
        do @(posedge i_clk); while (busy);
        predict_digits(a, b);
    endtask

    // Stop sending and wait for every owed digit, plus a short settle.
    task automatic drain_digits();
        @(negedge i_clk);
        start <= 1'b0;
        while (digits_due.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [BASE_W-1:0] value);
        drain_digits();
        @(negedge i_clk);
        i_cfg_we          <= 1'b1;
        i_cfg_number_base <= value;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        radix_reg = value;
    endtask

    // Mix of magnitudes: full width, randomly shifted, small and near-max.
    function automatic logic [ADDEND_W-1:0] rand_addend();
        logic [ADDEND_W-1:0] v;
        v = ADDEND_W'($urandom);
        case ($urandom_range(0, 3))
            0: v = v;
            1: v = v >> $urandom_range(0, ADDEND_W);
            2: v = ADDEND_W'($urandom_range(0, 300));
            default: v = ADDEND_MAX - ADDEND_W'($urandom_range(0, 300));
        endcase
        return v;
    endfunction

    // Edge sums at reset radix, then each clamp region of the radix.
    task automatic test_directed();
        send_item('0, '0);
        send_item(ADDEND_MAX, ADDEND_MAX);
        send_item(ADDEND_MAX, '0);
        send_item('0, ADDEND_MAX);
        send_item(9, 0);
        send_item(5, 5);
        send_item(0, 1);
        write_radix(0);                      // below range, acts as 2
        send_item(ADDEND_MAX, ADDEND_MAX);   // longest digit run
        send_item('0, '0);
        write_radix(1);
        send_item(1, 1);
        write_radix(16);
        send_item(ADDEND_MAX, ADDEND_MAX);
        send_item(15, 0);
        send_item(0, 16);
        write_radix(17);                     // above range, acts as 16
        send_item(255, 0);
        write_radix(31);
        send_item(ADDEND_MAX, 1);
        write_radix(2);
        send_item(3, 4);
        write_radix(15);
        send_item(14, 0);
        send_item(0, 15);
    endtask

    // Random items over a series of radix settings, gaps on or off per phase.
    task automatic test_random_radix();
        logic [BASE_W-1:0] extremes[6] = '{0, 31, 2, 16, 17, 1};
        for (int phase = 0; phase < 10; phase++) begin
            write_radix(phase < 6 ? extremes[phase] : BASE_W'($urandom_range(0, 31)));
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (22) send_item(rand_addend(), rand_addend());
        end
        no_gaps = 1'b0;
    endtask

    // Sender stops until all owed digits are out, every few items.
    task automatic test_drain_pause();
        write_radix(BASE_W'($urandom_range(3, 12)));
        repeat (4) begin
            repeat (5) send_item(rand_addend(), rand_addend());
            drain_digits();
        end
    endtask

    // Start held high across items: next item queued as soon as busy drops.
    task automatic test_back_to_back();
        write_radix(7);
        no_gaps = 1'b1;
        repeat (15) send_item(rand_addend(), rand_addend());
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_radix();
        test_drain_pause();
        test_back_to_back();

        @(negedge i_clk);
        start <= 1'b0;
        while (digits_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && digits_due.size() == 0) begin
            $display("radix_sum_digits verification clean");
        end else begin
            $display("radix_sum_digits verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rsd_pkg.sv
rtl/rsd_divider.sv
rtl/radix_sum_digits.sv
sim/testbench.sv
